// File: sv/rbei_pkg.sv
// Package with the word widths, opcodes, register indexes and register reset values of the integrator.
`default_nettype none
package rbei_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int IO_BITS = 32;
	localparam int CFG_BITS = 31;
	localparam int FUNC_BITS = 3;
	localparam int IDX_BITS = 3;

	// Item opcodes.
	localparam logic [FUNC_BITS-1:0] FN_TICK = 3'd0;
	localparam logic [FUNC_BITS-1:0] FN_FORCE = 3'd1;
	localparam logic [FUNC_BITS-1:0] FN_SET_POS = 3'd2;
	localparam logic [FUNC_BITS-1:0] FN_SET_VEL = 3'd3;
	localparam logic [FUNC_BITS-1:0] FN_SET_ANG = 3'd4;
	localparam logic [FUNC_BITS-1:0] FN_SET_SPIN = 3'd5;

	// Register indexes.
	localparam logic [IDX_BITS-1:0] REG_GRAV_X = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_GRAV_Y = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_DT = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_MASS = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_MOMENT = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_LIN_DRAG = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_ANG_DRAG = 3'd6;

	localparam logic [IO_BITS-1:0] GRAV_Y_RESET = 32'hFFF6_3333;
	localparam logic [CFG_BITS-1:0] DT_RESET = 31'd1092;
	localparam logic [CFG_BITS-1:0] ONE_RESET = 31'd65536;
endpackage
`default_nettype wire

// File: sv/rbei_if.sv
// Valid/ready channel interfaces for items, results and register writes.
`default_nettype none
interface rbei_in_if;
	logic valid;
	logic ready;
	logic [2:0] func;
	logic signed [31:0] force_x, force_y, point_x, point_y;
	logic signed [31:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_angle, new_spin;
	modport source (output valid, func, force_x, force_y, point_x, point_y, new_pos_x,
		new_pos_y, new_vel_x, new_vel_y, new_angle, new_spin, input ready);
	modport sink (input valid, func, force_x, force_y, point_x, point_y, new_pos_x,
		new_pos_y, new_vel_x, new_vel_y, new_angle, new_spin, output ready);
endinterface

interface rbei_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x, pos_y, vel_x, vel_y, angle, spin;
	modport source (output valid, pos_x, pos_y, vel_x, vel_y, angle, spin, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, angle, spin, output ready);
endinterface

interface rbei_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/rbei_mul.sv
// Shared fixed-point multiplier: four 32x32 partial products over cycles, then shift and saturate.
`default_nettype none
module rbei_mul #(
	parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = rbei_pkg::WORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [WORD_BITS-1:0] a,
	input wire logic signed [WORD_BITS-1:0] b,
	output logic done,
	output logic signed [WORD_BITS-1:0] y
);
	localparam int HB = 32;
	localparam int PW = 2 * WORD_BITS;
	localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	logic [WORD_BITS-1:0] x_q, z_q;
	logic neg_q;
	logic [PW-1:0] acc_q;
	logic [2:0] step_q;
	logic busy_q;
	logic [HB-1:0] xs, zs;
	logic [2*HB-1:0] pp;
	logic [PW+2*HB-1:0] pps;
	logic [PW-1:0] prod;
	logic [PW-1:0] shifted;
	logic ovf;

	// Pick the 32-bit halves for the current partial product.
	always_comb begin
		xs = HB'(step_q[0] ? (PW'(x_q) >> HB) : PW'(x_q));
		zs = HB'(step_q[1] ? (PW'(z_q) >> HB) : PW'(z_q));
		pp = (2*HB)'(xs) * (2*HB)'(zs);
		pps = (PW+2*HB)'(pp) << (HB * (32'(step_q[0]) + 32'(step_q[1])));
		prod = acc_q + PW'(pps);
		shifted = prod >> FRAC_BITS;
		ovf = neg_q ? (shifted > PW'(WMAX) + PW'(1)) : (shifted > PW'(WMAX));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 3'd3) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
			z_q <= b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
			neg_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= prod;
			if (step_q == 3'd3) begin
				if (ovf) y <= neg_q ? WMIN : WMAX;
				else if (neg_q) y <= WORD_BITS'(-shifted);
				else y <= WORD_BITS'(shifted);
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/rbei_div.sv
// Shared restoring divider: one quotient bit per cycle of (|a| << FRAC_BITS) / d, saturated.
`default_nettype none
module rbei_div #(
	parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = rbei_pkg::WORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [WORD_BITS-1:0] a,
	input wire logic [rbei_pkg::CFG_BITS-1:0] d,
	output logic done,
	output logic signed [WORD_BITS-1:0] y
);
	localparam int NB = WORD_BITS + FRAC_BITS;
	localparam int CW = $clog2(NB + 1);
	localparam int RB = rbei_pkg::CFG_BITS + 1;
	localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	logic [NB-1:0] num_q, quo_q;
	logic [RB-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic neg_q, busy_q;
	logic [RB-1:0] rtry;
	logic ge;
	logic [NB-1:0] qn;
	logic ovf;

	always_comb begin
		rtry = {rem_q[RB-2:0], num_q[NB-1]};
		ge = rtry >= RB'(d);
		qn = {quo_q[NB-2:0], ge};
		ovf = neg_q ? (qn > NB'(WMAX) + NB'(1)) : (qn > NB'(WMAX));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NB - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Shift in one numerator bit, subtract when it fits.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NB'(a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a)) << FRAC_BITS;
			quo_q <= '0;
			rem_q <= '0;
			neg_q <= a[WORD_BITS-1];
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? rtry - RB'(d) : rtry;
			quo_q <= qn;
			if (cnt_q == '0) begin
				if (ovf) y <= neg_q ? WMIN : WMAX;
				else if (neg_q) y <= WORD_BITS'(-qn);
				else y <= WORD_BITS'(qn);
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/rigid_body_euler_integrator_core.sv
// Top level: state registers, configuration, and the sequencer driving the shared units.
// A tick runs eleven multiplies in turn on the one shared multiplier, then the squaring,
// snapping and output states.
// A force item runs up to three serial divisions and two multiplies. Setter items and
// unused codes go straight to the output state. One item is in work at a time.
// Reset clears the state to zero and loads the register reset values; no clearing pass.
`default_nettype none
module rigid_body_euler_integrator_core #(
	parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = rbei_pkg::WORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rbei_in_if.sink in_ch,
	rbei_out_if.source out_ch,
	rbei_cfg_if.sink cfg
);
	localparam int W = WORD_BITS;
	localparam int IO = rbei_pkg::IO_BITS;
	localparam int CB = rbei_pkg::CFG_BITS;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	// Thresholds rounded to the nearest raw step.
	localparam longint unsigned ONE_RAW = 64'd1 << FRAC_BITS;
	localparam longint unsigned LIN_T = (ONE_RAW + 64'd5000) / 64'd10000;
	localparam longint unsigned ROT_T = (ONE_RAW + 64'd50000) / 64'd100000;
	// Squared speed is formed from the low LW bits of each part, enough for parts below the linear threshold.
	localparam int LW = $clog2(LIN_T + 64'd1);
	localparam int SQ_W = 2 * LW + 1;

	// Sequencer states.
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_GVX = 5'd1;
	localparam logic [4:0] ST_GVY = 5'd2;
	localparam logic [4:0] ST_PX = 5'd3;
	localparam logic [4:0] ST_PY = 5'd4;
	localparam logic [4:0] ST_ANG = 5'd5;
	localparam logic [4:0] ST_DX1 = 5'd6;
	localparam logic [4:0] ST_DX2 = 5'd7;
	localparam logic [4:0] ST_DY1 = 5'd8;
	localparam logic [4:0] ST_DY2 = 5'd9;
	localparam logic [4:0] ST_DS1 = 5'd10;
	localparam logic [4:0] ST_DS2 = 5'd11;
	localparam logic [4:0] ST_SQX = 5'd12;
	localparam logic [4:0] ST_SQY = 5'd13;
	localparam logic [4:0] ST_SNAP = 5'd14;
	localparam logic [4:0] ST_FDX = 5'd15;
	localparam logic [4:0] ST_FDY = 5'd16;
	localparam logic [4:0] ST_T1 = 5'd17;
	localparam logic [4:0] ST_T2 = 5'd18;
	localparam logic [4:0] ST_TD = 5'd19;
	localparam logic [4:0] ST_OUT = 5'd20;

	logic signed [IO-1:0] gx_q, gy_q;
	logic [CB-1:0] dt_q, mass_q, mom_q, ld_q, ad_q;
	logic signed [W-1:0] px_q, py_q, vx_q, vy_q, ang_q, spin_q;
	logic signed [W-1:0] fx_q, fy_q, ptx_q, pty_q, tmp_q;
	logic [SQ_W-1:0] sq_q;
	logic [4:0] st_q;
	logic issued_q;
	logic out_valid_q;

	logic mul_start, mul_done, div_start, div_done;
	logic signed [W-1:0] mul_a, mul_b, mul_y, div_a, div_y;
	logic [CB-1:0] div_d;

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = (W+1)'(a) + (W+1)'(b);
		if (s > (W+1)'(WMAX)) return WMAX;
		if (s < (W+1)'(WMIN)) return WMIN;
		return W'(s);
	endfunction

	function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = (W+1)'(a) - (W+1)'(b);
		if (s > (W+1)'(WMAX)) return WMAX;
		if (s < (W+1)'(WMIN)) return WMIN;
		return W'(s);
	endfunction

	// Bring a 32-bit port value into the word, saturating when the word is narrower.
	function automatic logic signed [W-1:0] fit(input logic signed [IO-1:0] v);
		logic signed [IO+W-1:0] e;
		e = (IO+W)'(v);
		if (e > (IO+W)'(WMAX)) return WMAX;
		if (e < (IO+W)'(WMIN)) return WMIN;
		return W'(e);
	endfunction

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	rbei_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .y(mul_y));

	rbei_div #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .a(div_a), .d(div_d),
		.done(div_done), .y(div_y));

	assign in_ch.ready = (st_q == ST_IDLE) && !out_valid_q;
	assign cfg.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.pos_x = IO'(px_q);
	assign out_ch.pos_y = IO'(py_q);
	assign out_ch.vel_x = IO'(vx_q);
	assign out_ch.vel_y = IO'(vy_q);
	assign out_ch.angle = IO'(ang_q);
	assign out_ch.spin = IO'(spin_q);

	// Operand selection for the shared units.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_a = '0;
		div_d = mass_q;
		unique case (st_q)
			ST_GVX: begin mul_a = fit(gx_q); mul_b = W'(dt_q); end
			ST_GVY: begin mul_a = fit(gy_q); mul_b = W'(dt_q); end
			ST_PX: begin mul_a = vx_q; mul_b = W'(dt_q); end
			ST_PY: begin mul_a = vy_q; mul_b = W'(dt_q); end
			ST_ANG: begin mul_a = spin_q; mul_b = W'(dt_q); end
			ST_DX1: begin mul_a = vx_q; mul_b = W'(ld_q); end
			ST_DY1: begin mul_a = vy_q; mul_b = W'(ld_q); end
			ST_DS1: begin mul_a = spin_q; mul_b = W'(ad_q); end
			ST_DX2, ST_DY2, ST_DS2: begin mul_a = tmp_q; mul_b = W'(dt_q); end
			ST_T1: begin mul_a = fy_q; mul_b = ptx_q; end
			ST_T2: begin mul_a = fx_q; mul_b = pty_q; end
			ST_FDX: div_a = fx_q;
			ST_FDY: div_a = fy_q;
			ST_TD: begin div_a = tmp_q; div_d = mom_q; end
			default: ;
		endcase
		mul_start = !issued_q && (st_q >= ST_GVX && st_q <= ST_DS2 ||
			st_q == ST_T1 || st_q == ST_T2);
		div_start = !issued_q && (st_q == ST_FDX || st_q == ST_FDY || st_q == ST_TD);
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q <= '0;
			gy_q <= rbei_pkg::GRAV_Y_RESET;
			dt_q <= rbei_pkg::DT_RESET;
			mass_q <= rbei_pkg::ONE_RESET;
			mom_q <= rbei_pkg::ONE_RESET;
			ld_q <= '0;
			ad_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rbei_pkg::REG_GRAV_X: gx_q <= cfg.data;
				rbei_pkg::REG_GRAV_Y: gy_q <= cfg.data;
				rbei_pkg::REG_DT: dt_q <= CB'(cfg.data);
				rbei_pkg::REG_MASS: mass_q <= CB'(cfg.data);
				rbei_pkg::REG_MOMENT: mom_q <= CB'(cfg.data);
				rbei_pkg::REG_LIN_DRAG: ld_q <= CB'(cfg.data);
				rbei_pkg::REG_ANG_DRAG: ad_q <= CB'(cfg.data);
				default: ;
			endcase
		end
	end

	// Sequencer and state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			issued_q <= 1'b0;
			out_valid_q <= 1'b0;
			px_q <= '0; py_q <= '0; vx_q <= '0; vy_q <= '0; ang_q <= '0; spin_q <= '0;
			fx_q <= '0; fy_q <= '0; ptx_q <= '0; pty_q <= '0; tmp_q <= '0;
			sq_q <= '0;
		end else begin
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (mul_start || div_start) issued_q <= 1'b1;
			unique case (st_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						fx_q <= fit(in_ch.force_x);
						fy_q <= fit(in_ch.force_y);
						ptx_q <= fit(in_ch.point_x);
						pty_q <= fit(in_ch.point_y);
						unique case (in_ch.func)
							rbei_pkg::FN_TICK: st_q <= ST_GVX;
							rbei_pkg::FN_FORCE: st_q <= (mass_q != '0) ? ST_FDX :
								(mom_q != '0) ? ST_T1 : ST_OUT;
							rbei_pkg::FN_SET_POS: begin
								px_q <= fit(in_ch.new_pos_x);
								py_q <= fit(in_ch.new_pos_y);
								st_q <= ST_OUT;
							end
							rbei_pkg::FN_SET_VEL: begin
								vx_q <= fit(in_ch.new_vel_x);
								vy_q <= fit(in_ch.new_vel_y);
								st_q <= ST_OUT;
							end
							rbei_pkg::FN_SET_ANG: begin
								ang_q <= fit(in_ch.new_angle);
								st_q <= ST_OUT;
							end
							rbei_pkg::FN_SET_SPIN: begin
								spin_q <= fit(in_ch.new_spin);
								st_q <= ST_OUT;
							end
							default: st_q <= ST_OUT;
						endcase
					end
				end
				ST_SQX: begin
					// Squared speed only matters when both parts are below the threshold.
					sq_q <= SQ_W'(LW'(mag(vx_q))) * SQ_W'(LW'(mag(vx_q)));
					st_q <= ST_SQY;
				end
				ST_SQY: begin
					sq_q <= sq_q + SQ_W'(LW'(mag(vy_q))) * SQ_W'(LW'(mag(vy_q)));
					st_q <= ST_SNAP;
				end
				ST_SNAP: begin
					if (mag(vx_q) < W'(LIN_T) && mag(vy_q) < W'(LIN_T) &&
						sq_q < SQ_W'(LIN_T * LIN_T)) begin
						vx_q <= '0;
						vy_q <= '0;
					end
					if (mag(spin_q) < W'(ROT_T)) spin_q <= '0;
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: begin
					if (mul_done) begin
						issued_q <= 1'b0;
						unique case (st_q)
							ST_GVX: begin vx_q <= sat_add(vx_q, mul_y); st_q <= ST_GVY; end
							ST_GVY: begin vy_q <= sat_add(vy_q, mul_y); st_q <= ST_PX; end
							ST_PX: begin px_q <= sat_add(px_q, mul_y); st_q <= ST_PY; end
							ST_PY: begin py_q <= sat_add(py_q, mul_y); st_q <= ST_ANG; end
							ST_ANG: begin ang_q <= sat_add(ang_q, mul_y); st_q <= ST_DX1; end
							ST_DX1: begin tmp_q <= mul_y; st_q <= ST_DX2; end
							ST_DX2: begin vx_q <= sat_sub(vx_q, mul_y); st_q <= ST_DY1; end
							ST_DY1: begin tmp_q <= mul_y; st_q <= ST_DY2; end
							ST_DY2: begin vy_q <= sat_sub(vy_q, mul_y); st_q <= ST_DS1; end
							ST_DS1: begin tmp_q <= mul_y; st_q <= ST_DS2; end
							ST_DS2: begin spin_q <= sat_sub(spin_q, mul_y); st_q <= ST_SQX; end
							ST_T1: begin tmp_q <= mul_y; st_q <= ST_T2; end
							ST_T2: begin tmp_q <= sat_sub(tmp_q, mul_y); st_q <= ST_TD; end
							default: ;
						endcase
					end
					if (div_done) begin
						issued_q <= 1'b0;
						unique case (st_q)
							ST_FDX: begin vx_q <= sat_add(vx_q, div_y); st_q <= ST_FDY; end
							ST_FDY: begin
								vy_q <= sat_add(vy_q, div_y);
								st_q <= (mom_q != '0) ? ST_T1 : ST_OUT;
							end
							ST_TD: begin spin_q <= sat_add(spin_q, div_y); st_q <= ST_OUT; end
							default: ;
						endcase
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sim/rigid_body_euler_integrator_core_tb.sv
// Self-checking testbench for the rigid body integrator core: random items, idling and register phases.
`default_nettype none
module rigid_body_euler_integrator_core_tb;
	localparam int FB = 16;
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;
	localparam longint LIN_T = 7;
	localparam longint ROT_T = 1;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic [2:0] func;
		logic [31:0] force_x, force_y, point_x, point_y;
		logic [31:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_angle, new_spin;
	} item_t;

	typedef struct packed {
		logic [31:0] pos_x, pos_y, vel_x, vel_y, angle, spin;
	} body_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_sent = 1'b0;

	rbei_in_if in_ch();
	rbei_out_if out_ch();
	rbei_cfg_if cfg();

	rigid_body_euler_integrator_core DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	always #5 clk = ~clk;

	// Predictor state and register copy.
	longint px, py, vx, vy, ang, spn;
	longint grav_x, grav_y, dt, mass, moment, ldrag, adrag;

	item_t pending[$];
	body_t expected_bodies[$];
	int src_idle_pct = 7;
	int snk_idle_pct = 72;
	int errors = 0;
	int results_seen = 0;
	int cycles = 0;
	int mix_count[8];

	function automatic longint sat(longint v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return v;
	endfunction

	// Sign-extended 32-bit value.
	function automatic longint sx(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	// Fixed-point product, truncated toward zero and saturated.
	function automatic longint fmul(longint a, longint b);
		logic signed [127:0] p;
		logic [127:0] m;
		logic neg;
		p = 128'(signed'(a)) * 128'(signed'(b));
		neg = p[127];
		m = neg ? -p : p;
		m = m >> FB;
		if (neg) begin
			if (m >= 128'd2147483648) return WMIN;
			return -longint'(m[63:0]);
		end
		if (m > 128'd2147483647) return WMAX;
		return longint'(m[63:0]);
	endfunction

	// Fixed-point quotient by a positive divisor, truncated and saturated.
	function automatic longint fdiv(longint a, longint d);
		logic [127:0] m;
		logic neg;
		neg = a < 0;
		m = 128'(neg ? -a : a) << FB;
		m = m / 128'(d);
		if (neg) begin
			if (m >= 128'd2147483648) return WMIN;
			return -longint'(m[63:0]);
		end
		if (m > 128'd2147483647) return WMAX;
		return longint'(m[63:0]);
	endfunction

	function automatic longint absv(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Advances the predicted body by one item and returns its state.
	function automatic body_t integrate(item_t it);
		body_t b;
		longint fx, fy, tq, mx, my;
		case (it.func)
			rbei_pkg::FN_TICK: begin
				vx = sat(vx + fmul(grav_x, dt));
				vy = sat(vy + fmul(grav_y, dt));
				px = sat(px + fmul(vx, dt));
				py = sat(py + fmul(vy, dt));
				ang = sat(ang + fmul(spn, dt));
				vx = sat(vx - fmul(fmul(vx, ldrag), dt));
				vy = sat(vy - fmul(fmul(vy, ldrag), dt));
				spn = sat(spn - fmul(fmul(spn, adrag), dt));
				mx = absv(vx);
				my = absv(vy);
				if (mx < LIN_T && my < LIN_T && mx * mx + my * my < LIN_T * LIN_T) begin
					vx = 0;
					vy = 0;
				end
				if (absv(spn) < ROT_T) spn = 0;
			end
			rbei_pkg::FN_FORCE: begin
				fx = sx(it.force_x);
				fy = sx(it.force_y);
				if (mass != 0) begin
					vx = sat(vx + fdiv(fx, mass));
					vy = sat(vy + fdiv(fy, mass));
				end
				if (moment != 0) begin
					tq = sat(fmul(fy, sx(it.point_x)) - fmul(fx, sx(it.point_y)));
					spn = sat(spn + fdiv(tq, moment));
				end
			end
			rbei_pkg::FN_SET_POS: begin
				px = sx(it.new_pos_x);
				py = sx(it.new_pos_y);
			end
			rbei_pkg::FN_SET_VEL: begin
				vx = sx(it.new_vel_x);
				vy = sx(it.new_vel_y);
			end
			rbei_pkg::FN_SET_ANG: ang = sx(it.new_angle);
			rbei_pkg::FN_SET_SPIN: spn = sx(it.new_spin);
			default: ;
		endcase
		b.pos_x = px[31:0];
		b.pos_y = py[31:0];
		b.vel_x = vx[31:0];
		b.vel_y = vy[31:0];
		b.angle = ang[31:0];
		b.spin = spn[31:0];
		return b;
	endfunction

	// Driver: presents pending words on the falling edge and holds each until it is taken.
	always @(negedge clk) begin
		if (!in_ch.valid || in_sent) begin
			if (pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				{in_ch.func, in_ch.force_x, in_ch.force_y, in_ch.point_x, in_ch.point_y,
					in_ch.new_pos_x, in_ch.new_pos_y, in_ch.new_vel_x, in_ch.new_vel_y,
					in_ch.new_angle, in_ch.new_spin} <= pending[0];
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
		out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Acceptance on the input side: the word leaves the queue and is predicted.
	always @(posedge clk) begin
		in_sent <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			mix_count[in_ch.func] <= mix_count[in_ch.func] + 1;
			expected_bodies.push_back(integrate(pending.pop_front()));
		end
	end

	// Monitor: compares each result word with the oldest expectation.
	always @(posedge clk) begin
		body_t e;
		cycles <= cycles + 1;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen <= results_seen + 1;
			if (expected_bodies.size() == 0) begin
				$error("result word with no expectation waiting");
				errors = errors + 1;
			end else begin
				e = expected_bodies.pop_front();
				if (out_ch.pos_x !== e.pos_x) begin
					$error("pos_x expected %h actual %h", e.pos_x, out_ch.pos_x);
					errors = errors + 1;
				end
				if (out_ch.pos_y !== e.pos_y) begin
					$error("pos_y expected %h actual %h", e.pos_y, out_ch.pos_y);
					errors = errors + 1;
				end
				if (out_ch.vel_x !== e.vel_x) begin
					$error("vel_x expected %h actual %h", e.vel_x, out_ch.vel_x);
					errors = errors + 1;
				end
				if (out_ch.vel_y !== e.vel_y) begin
					$error("vel_y expected %h actual %h", e.vel_y, out_ch.vel_y);
					errors = errors + 1;
				end
				if (out_ch.angle !== e.angle) begin
					$error("angle expected %h actual %h", e.angle, out_ch.angle);
					errors = errors + 1;
				end
				if (out_ch.spin !== e.spin) begin
					$error("spin expected %h actual %h", e.spin, out_ch.spin);
					errors = errors + 1;
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Writes one register while the block is idle and mirrors it.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg.index <= idx;
		cfg.data <= val;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			rbei_pkg::REG_GRAV_X: grav_x = sx(val);
			rbei_pkg::REG_GRAV_Y: grav_y = sx(val);
			rbei_pkg::REG_DT: dt = longint'(val[30:0]);
			rbei_pkg::REG_MASS: mass = longint'(val[30:0]);
			rbei_pkg::REG_MOMENT: moment = longint'(val[30:0]);
			rbei_pkg::REG_LIN_DRAG: ldrag = longint'(val[30:0]);
			rbei_pkg::REG_ANG_DRAG: adrag = longint'(val[30:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending.size() > 0 || expected_bodies.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(40)) - 20);
			3: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t rnd_item();
		item_t it;
		int r;
		it = '0;
		r = $urandom_range(99);
		if (r < 45) it.func = rbei_pkg::FN_TICK;
		else if (r < 65) it.func = rbei_pkg::FN_FORCE;
		else if (r < 96) it.func = 3'($urandom_range(2, 5));
		else it.func = 3'($urandom_range(6, 7));
		it.force_x = rnd_word();
		it.force_y = rnd_word();
		it.point_x = rnd_word();
		it.point_y = rnd_word();
		it.new_pos_x = rnd_word();
		it.new_pos_y = rnd_word();
		it.new_vel_x = rnd_word();
		it.new_vel_y = rnd_word();
		it.new_angle = rnd_word();
		it.new_spin = rnd_word();
		return it;
	endfunction

	function automatic item_t mk(logic [2:0] f, logic [31:0] a, logic [31:0] b);
		item_t it;
		it = '0;
		it.func = f;
		it.force_x = a;
		it.force_y = b;
		it.point_x = b;
		it.point_y = a;
		it.new_pos_x = a;
		it.new_pos_y = b;
		it.new_vel_x = a;
		it.new_vel_y = b;
		it.new_angle = a;
		it.new_spin = b;
		return it;
	endfunction

	// Stimulus and phase control.
	initial begin
		in_ch.valid = 1'b0;
		in_ch.func = '0;
		{in_ch.force_x, in_ch.force_y, in_ch.point_x, in_ch.point_y} = '0;
		{in_ch.new_pos_x, in_ch.new_pos_y, in_ch.new_vel_x, in_ch.new_vel_y} = '0;
		{in_ch.new_angle, in_ch.new_spin} = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		for (int i = 0; i < 8; i++) mix_count[i] = 0;
		px = 0; py = 0; vx = 0; vy = 0; ang = 0; spn = 0;
		grav_x = 0; grav_y = sx(rbei_pkg::GRAV_Y_RESET); dt = rbei_pkg::DT_RESET;
		mass = rbei_pkg::ONE_RESET; moment = rbei_pkg::ONE_RESET; ldrag = 0; adrag = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part with reset registers: every opcode, extremes, snapping, unused codes.
		pending.push_back(mk(rbei_pkg::FN_TICK, 0, 0));
		pending.push_back(mk(rbei_pkg::FN_SET_VEL, 32'd3, 32'hFFFF_FFFC));
		pending.push_back(mk(rbei_pkg::FN_SET_SPIN, 32'd0, 32'd0));
		pending.push_back(mk(rbei_pkg::FN_FORCE, 32'h0001_0000, 32'h0002_0000));
		pending.push_back(mk(rbei_pkg::FN_SET_POS, 32'h7FFF_FFFF, 32'h8000_0000));
		pending.push_back(mk(rbei_pkg::FN_SET_VEL, 32'h7FFF_FFFF, 32'h8000_0000));
		pending.push_back(mk(rbei_pkg::FN_TICK, 0, 0));
		pending.push_back(mk(rbei_pkg::FN_SET_ANG, 32'h8000_0000, 0));
		pending.push_back(mk(rbei_pkg::FN_SET_SPIN, 0, 32'h7FFF_FFFF));
		pending.push_back(mk(rbei_pkg::FN_FORCE, 32'h7FFF_FFFF, 32'h8000_0000));
		pending.push_back(mk(rbei_pkg::FN_FORCE, 32'h8000_0000, 32'h8000_0000));
		pending.push_back(mk(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending.push_back(mk(3'd7, 0, 0));
		pending.push_back(mk(rbei_pkg::FN_SET_VEL, 32'd4, 32'd5));
		pending.push_back(mk(rbei_pkg::FN_TICK, 0, 0));
		wait_drained();

		// Zero divisors, unknown index, extreme registers.
		write_reg(rbei_pkg::REG_MASS, 32'd0);
		write_reg(rbei_pkg::REG_MOMENT, 32'd0);
		write_reg(3'd7, 32'h1234_5678);
		pending.push_back(mk(rbei_pkg::FN_FORCE, 32'h0005_0000, 32'h0003_0000));
		wait_drained();
		write_reg(rbei_pkg::REG_GRAV_X, 32'h7FFF_FFFF);
		write_reg(rbei_pkg::REG_GRAV_Y, 32'h8000_0000);
		write_reg(rbei_pkg::REG_DT, 32'hFFFF_FFFF);
		write_reg(rbei_pkg::REG_LIN_DRAG, 32'h7FFF_FFFF);
		write_reg(rbei_pkg::REG_ANG_DRAG, 32'h7FFF_FFFF);
		pending.push_back(mk(rbei_pkg::FN_SET_VEL, 32'h0001_0000, 32'hFFFF_0000));
		pending.push_back(mk(rbei_pkg::FN_SET_SPIN, 0, 32'h0001_0000));
		pending.push_back(mk(rbei_pkg::FN_TICK, 0, 0));
		pending.push_back(mk(rbei_pkg::FN_TICK, 0, 0));
		wait_drained();

		// Random phases with varied registers and idling.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(rbei_pkg::REG_GRAV_X, rnd_word());
			write_reg(rbei_pkg::REG_GRAV_Y,
				32'($signed($urandom_range(1 << 21)) - (1 << 20)));
			write_reg(rbei_pkg::REG_DT, ph == 5 ? 32'd0 : 32'($urandom_range(1, 1 << 14)));
			write_reg(rbei_pkg::REG_MASS,
				ph == 4 ? 32'd1 : 32'($urandom_range(1 << 10, 1 << 20)));
			write_reg(rbei_pkg::REG_MOMENT,
				ph == 4 ? 32'h7FFF_FFFF : 32'($urandom_range(1 << 10, 1 << 20)));
			write_reg(rbei_pkg::REG_LIN_DRAG, 32'($urandom_range(0, 1 << 18)));
			write_reg(rbei_pkg::REG_ANG_DRAG, 32'($urandom_range(0, 1 << 18)));
			src_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 72 : 0;
			snk_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 7 : 0;
			for (int i = 0; i < 170; i++) pending.push_back(rnd_item());
			wait_drained();
		end

		$display("covered %0d results: ticks %0d, forces %0d, setters %0d, unused %0d",
			results_seen, mix_count[0], mix_count[1],
			mix_count[2] + mix_count[3] + mix_count[4] + mix_count[5],
			mix_count[6] + mix_count[7]);
		$display("eight register settings including zero divisors and saturating extremes");
		if (errors == 0 && expected_bodies.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
sv/rbei_pkg.sv
sv/rbei_if.sv
sv/rbei_mul.sv
sv/rbei_div.sv
sv/rigid_body_euler_integrator_core.sv
sim/rigid_body_euler_integrator_core_tb.sv
